/* hw/rtl/nrls_pkg.sv */
// ----------------------------------------------------------------------------
// nrls_pkg
// Types and constants shared by the rate limited NRPN sender.
// ----------------------------------------------------------------------------
package nrls_pkg;

  // request codes
  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_FLUSH   = 2'd2;

  // controller numbers, in send order
  localparam logic [6:0] CC_PARAM_MSB = 7'd99;
  localparam logic [6:0] CC_PARAM_LSB = 7'd98;
  localparam logic [6:0] CC_DATA_LSB  = 7'd38;
  localparam logic [6:0] CC_DATA_MSB  = 7'd6;

  localparam logic [3:0] STATUS_CTRL_CHANGE = 4'hB;

  localparam logic [7:0]  CHANNEL_MAX = 8'd15;
  localparam logic [15:0] PARAM_MAX   = 16'h3FFF;
  localparam logic [15:0] VALUE_MAX   = 16'h7FFF;

  localparam int RATE_MIN     = 10;
  localparam int RATE_MAX     = 1000;
  localparam int RATE_RESET   = 100;
  localparam int TICK_DIVISOR = 60;

  // floor(v * RATE_RECIP / 2^16) equals v / 60 for every v up to RATE_MAX
  localparam int RATE_RECIP = 1093;
  localparam int RECIP_SHIFT = 16;

  localparam int BUDGET_W = 5;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET =
    (RATE_RESET / TICK_DIVISOR) < 1 ? BUDGET_W'(1) : BUDGET_W'(RATE_RESET / TICK_DIVISOR);

  localparam int DEFAULT_QUEUE_DEPTH = 256;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  channel_in;
    logic [15:0] param_number;
    logic [15:0] param_value;
  } req_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] controller_number;
    logic [6:0] controller_value;
    logic       last_of_tick;
    logic [4:0] sent_count;
    logic       enqueue_dropped;
  } res_t;

  // one queued request after clamping
  typedef struct packed {
    logic [3:0]  channel;
    logic [13:0] param;
    logic [14:0] value;
  } entry_t;

endpackage

/* hw/rtl/nrpn_rate_limited_sender_unit.sv */
// ----------------------------------------------------------------------------
// nrpn_rate_limited_sender_unit
// Queues clamped NRPN requests in a memory and drains up to rate/60 of them
// per tick (at least one), each as four controller change messages.
// ----------------------------------------------------------------------------
//  channel   signals                        word
//  request   req_valid / req_ready          req_word  (req_t)
//  result    res_valid / res_ready          res_word  (res_t)
//  config    cfg_we                         cfg_data  (send rate)
//
//  an enqueue, flush or empty tick is done in ST_IDLE; a full queue gives one
//  drop word. a tick sending n requests first reads the queue memory in
//  ST_FETCH, then sends one word per cycle while the result is not stalled,
//  the next entry being read while the last word of the current one goes out.
//  rst is synchronous; the queue memory needs no clearing.
//  a stalled result holds the sender and the request channel.
// ----------------------------------------------------------------------------
module nrpn_rate_limited_sender_unit
  import nrls_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req_word,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res_word,
  input  logic       cfg_we,
  input  logic [9:0] cfg_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = (CW > BUDGET_W) ? CW : BUDGET_W;
  localparam int PRODW = 21;

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_SEND} state_t;

  state_t              state;
  logic [PW-1:0]       rd_ptr;
  logic [PW-1:0]       wr_ptr;
  logic [CW-1:0]       entry_count;
  logic [BUDGET_W-1:0] budget;
  logic [BUDGET_W-1:0] left;
  logic [BUDGET_W-1:0] total;
  logic [1:0]          phase;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;

  logic          load_ok;
  logic          accept;
  logic          is_full;
  logic          mem_we;
  logic          rd_adv;
  logic          res_load;
  entry_t        entry_in;
  logic [PW-1:0] rd_ptr_next;
  logic [PW-1:0] wr_ptr_next;
  logic [BUDGET_W-1:0] take_n;
  logic [9:0]          rate_cl;
  logic [PRODW-1:0]    rate_prod;
  logic [BUDGET_W-1:0] budget_next;
  res_t                msg;
  res_t                drop_word;

  assign load_ok   = !res_valid || res_ready;
  assign req_ready = (state == ST_IDLE) && load_ok;
  assign accept    = req_valid && req_ready;
  assign is_full   = (entry_count == CW'(QUEUE_DEPTH));

  assign mem_we = accept && (req_word.req_type == REQ_ENQUEUE) && !is_full;
  assign rd_adv = (state == ST_FETCH) ||
                  ((state == ST_SEND) && load_ok && (phase == 2'd3) &&
                   (left != BUDGET_W'(1)));

  // a new word goes into the output register this cycle
  assign res_load = ((state == ST_SEND) && load_ok) ||
                    (accept && (req_word.req_type == REQ_ENQUEUE) && is_full);

  assign rd_ptr_next = (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
  assign wr_ptr_next = (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);

  // clamp on the way in
  always_comb begin
    entry_in.channel = (req_word.channel_in > CHANNEL_MAX) ? 4'hF :
                       req_word.channel_in[3:0];
    entry_in.param   = (req_word.param_number > PARAM_MAX) ? PARAM_MAX[13:0] :
                       req_word.param_number[13:0];
    entry_in.value   = (req_word.param_value > VALUE_MAX) ? VALUE_MAX[14:0] :
                       req_word.param_value[14:0];
  end

  always_comb begin
    drop_word                 = '0;
    drop_word.enqueue_dropped = 1'b1;
  end

  assign take_n = (MW'(entry_count) < MW'(budget)) ? BUDGET_W'(MW'(entry_count)) : budget;

  // per-tick budget worked out once at the register write
  always_comb begin
    if (cfg_data < 10'(RATE_MIN)) begin
      rate_cl = 10'(RATE_MIN);
    end else if (cfg_data > 10'(RATE_MAX)) begin
      rate_cl = 10'(RATE_MAX);
    end else begin
      rate_cl = cfg_data;
    end
    rate_prod   = PRODW'(rate_cl) * PRODW'(RATE_RECIP);
    budget_next = rate_prod[RECIP_SHIFT +: BUDGET_W];
    if (budget_next == '0) begin
      budget_next = BUDGET_W'(1);
    end
  end

  // message for the current phase of the entry just read
  always_comb begin
    msg                 = '0;
    msg.status_byte     = {STATUS_CTRL_CHANGE, rd_q.channel};
    case (phase)
      2'd0: begin
        msg.controller_number = CC_PARAM_MSB;
        msg.controller_value  = {1'b0, rd_q.param[13:8]};
      end
      2'd1: begin
        msg.controller_number = CC_PARAM_LSB;
        msg.controller_value  = rd_q.param[6:0];
      end
      2'd2: begin
        msg.controller_number = CC_DATA_LSB;
        msg.controller_value  = rd_q.value[7:1];
      end
      default: begin
        msg.controller_number = CC_DATA_MSB;
        msg.controller_value  = rd_q.value[14:8];
        if (left == BUDGET_W'(1)) begin
          msg.last_of_tick = 1'b1;
          msg.sent_count   = total;
        end
      end
    endcase
  end

  // queue memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= entry_in;
    end
    if (rd_adv) begin
      rd_q <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      entry_count <= '0;
      budget      <= BUDGET_RESET;
      left        <= '0;
      total       <= '0;
      phase       <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        budget <= budget_next;
      end
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      if (rd_adv) begin
        rd_ptr <= rd_ptr_next;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req_word.req_type)
              REQ_ENQUEUE: begin
                if (is_full) begin
                  res_valid <= 1'b1;
                  res_word  <= drop_word;
                end else begin
                  wr_ptr      <= wr_ptr_next;
                  entry_count <= entry_count + CW'(1);
                end
              end
              REQ_TICK: begin
                if (entry_count != '0) begin
                  left        <= take_n;
                  total       <= take_n;
                  entry_count <= entry_count - CW'(MW'(take_n));
                  state       <= ST_FETCH;
                end
              end
              REQ_FLUSH: begin
                rd_ptr      <= '0;
                wr_ptr      <= '0;
                entry_count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FETCH: begin
          phase <= '0;
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (load_ok) begin
            res_valid <= 1'b1;
            res_word  <= msg;
            phase     <= phase + 2'd1;
            if (phase == 2'd3) begin
              left <= left - BUDGET_W'(1);
              if (left == BUDGET_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
